// ===== sv/mbsp_pkg.sv =====
// Package for the MIDI byte stream parser: status codes, result and state
// types, and the data-byte count lookup. Depends on nothing.
package mbsp_pkg;

    localparam int SYSEX_COUNT_BITS = 16;

    // Status codes (channel messages with the channel nibble cleared).
    localparam logic [7:0] ST_NOTE_OFF    = 8'h80;
    localparam logic [7:0] ST_NOTE_ON     = 8'h90;
    localparam logic [7:0] ST_POLY_PRESS  = 8'hA0;
    localparam logic [7:0] ST_CONTROL     = 8'hB0;
    localparam logic [7:0] ST_PROGRAM     = 8'hC0;
    localparam logic [7:0] ST_CHAN_PRESS  = 8'hD0;
    localparam logic [7:0] ST_PITCH_BEND  = 8'hE0;
    localparam logic [7:0] ST_SYSEX       = 8'hF0;
    localparam logic [7:0] ST_SONG_POS    = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
    localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
    localparam logic [7:0] ST_EOX         = 8'hF7;
    localparam logic [7:0] ST_CLOCK       = 8'hF8;
    localparam logic [7:0] ST_START       = 8'hFA;
    localparam logic [7:0] ST_CONTINUE    = 8'hFB;
    localparam logic [7:0] ST_STOP        = 8'hFC;
    localparam logic [7:0] ST_SENSE       = 8'hFE;
    localparam logic [7:0] ST_RESET       = 8'hFF;
    localparam logic [7:0] ST_NONE        = 8'h00;

    localparam logic [7:0] TYPE_MASK      = 8'hF0;
    localparam logic [4:0] CHAN_SYSTEM    = 5'd16;

    // Data bytes needed after a status byte.
    localparam logic [1:0] NEED_ZERO      = 2'd0;
    localparam logic [1:0] NEED_ONE       = 2'd1;
    localparam logic [1:0] NEED_TWO       = 2'd2;
    localparam logic [1:0] NEED_UNKNOWN   = 2'd3;

    localparam logic       KIND_EVENT     = 1'b0;
    localparam logic       KIND_SYSEX     = 1'b1;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  message_type;
        logic [4:0]  channel;
        logic [6:0]  first_data;
        logic [6:0]  second_data;
        logic [13:0] wide_value;
        logic [15:0] sysex_length;
        logic [63:0] event_time;
    } t_result;

    typedef struct packed {
        logic [7:0]                  running_status;
        logic [7:0]                  pending_type;
        logic [4:0]                  pending_channel;
        logic [1:0]                  bytes_awaited;
        logic [6:0]                  held_data;
        logic                        in_sysex;
        logic [SYSEX_COUNT_BITS-1:0] sysex_count;
    } t_state;

    function automatic logic [1:0] f_data_needed(input logic [7:0] status);
        logic [1:0] need;
        unique case (status) inside
            ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CONTROL, ST_PITCH_BEND,
            ST_SONG_POS:
                need = NEED_TWO;
            ST_PROGRAM, ST_CHAN_PRESS, ST_SONG_SEL:
                need = NEED_ONE;
            ST_TUNE_REQ, ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP, ST_SENSE,
            ST_RESET:
                need = NEED_ZERO;
            default:
                need = NEED_UNKNOWN;
        endcase
        return need;
    endfunction

endpackage

// ===== sv/mbsp_step.sv =====
// Per-byte decode of the MIDI parser: next parser state and the result word.
// Depends on mbsp_pkg.
module mbsp_step
    import mbsp_pkg::*;
(
    input  t_state      i_state,
    input  logic [7:0]  i_data_byte,
    input  logic [63:0] i_time_stamp,
    output t_state      o_state,
    output logic        o_emit,
    output t_result     o_result
);

    localparam int EXT_BITS = SYSEX_COUNT_BITS + 16;

    logic [EXT_BITS-1:0] w_count_ext;
    logic [15:0]         w_length;
    logic [1:0]          w_need;
    logic [7:0]          w_run_type;

    // Build a completed message event from its type, channel and data bytes.
    function automatic t_result f_finish(input logic [7:0] kind_type,
                                         input logic [4:0] chan,
                                         input logic [6:0] a,
                                         input logic [6:0] b,
                                         input logic [63:0] t);
        t_result r;
        r              = '0;
        r.result_kind  = KIND_EVENT;
        r.message_type = kind_type;
        r.channel      = chan;
        r.event_time   = t;
        unique case (kind_type) inside
            ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CONTROL: begin
                r.first_data  = a;
                r.second_data = b;
                if (kind_type == ST_NOTE_ON && b == 7'd0) begin
                    r.message_type = ST_NOTE_OFF;
                end
                if (r.message_type == ST_NOTE_OFF) begin
                    r.second_data = 7'd0;
                end
            end
            ST_PROGRAM, ST_CHAN_PRESS, ST_SONG_SEL: begin
                r.first_data = a;
            end
            ST_PITCH_BEND, ST_SONG_POS: begin
                r.wide_value = {b, a};
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    assign w_count_ext = {16'd0, i_state.sysex_count};
    assign w_length    = (w_count_ext[EXT_BITS-1:16] != '0) ? 16'hFFFF
                                                             : w_count_ext[15:0];
    assign w_need      = f_data_needed(i_data_byte);
    assign w_run_type  = i_state.running_status & TYPE_MASK;

    always_comb begin
        o_state             = i_state;
        o_emit              = 1'b0;
        o_result            = '0;
        o_result.event_time = i_time_stamp;

        if (i_state.in_sysex) begin
            o_result.message_type = ST_SYSEX;
            o_result.channel      = CHAN_SYSTEM;
            o_emit                = 1'b1;
            if (i_data_byte == ST_EOX) begin
                o_state.in_sysex      = 1'b0;
                o_state.sysex_count   = '0;
                o_state.pending_type  = ST_NONE;
                o_result.result_kind  = KIND_EVENT;
                o_result.sysex_length = w_length;
            end else begin
                if (!(&i_state.sysex_count)) begin
                    o_state.sysex_count = i_state.sysex_count + 1'b1;
                end
                o_result.result_kind = KIND_SYSEX;
                o_result.first_data  = i_data_byte[6:0];
            end
        end else if (i_state.bytes_awaited != 2'd0) begin
            // Any byte counts as data here.
            if (i_state.bytes_awaited[1]) begin
                o_state.held_data     = i_data_byte[6:0];
                o_state.bytes_awaited = NEED_ONE;
            end else begin
                o_emit                = 1'b1;
                o_state.pending_type  = ST_NONE;
                o_state.bytes_awaited = 2'd0;
                o_state.held_data     = 7'd0;
                if (f_data_needed(i_state.pending_type) == NEED_TWO) begin
                    o_result = f_finish(i_state.pending_type, i_state.pending_channel,
                                        i_state.held_data, i_data_byte[6:0],
                                        i_time_stamp);
                end else begin
                    o_result = f_finish(i_state.pending_type, i_state.pending_channel,
                                        i_data_byte[6:0], 7'd0, i_time_stamp);
                end
            end
        end else if (i_data_byte[7]) begin
            if (i_data_byte < ST_SYSEX) begin
                o_state.running_status  = i_data_byte;
                o_state.pending_type    = i_data_byte & TYPE_MASK;
                o_state.pending_channel = {1'b0, i_data_byte[3:0]};
                o_state.bytes_awaited   = f_data_needed(i_data_byte & TYPE_MASK);
            end else begin
                if (i_data_byte[7:3] == ST_SYSEX[7:3]) begin
                    o_state.running_status = ST_NONE;
                end
                if (i_data_byte == ST_SYSEX) begin
                    o_state.in_sysex        = 1'b1;
                    o_state.sysex_count     = '0;
                    o_state.pending_type    = ST_SYSEX;
                    o_state.pending_channel = CHAN_SYSTEM;
                end else if (w_need != NEED_UNKNOWN) begin
                    o_state.pending_type    = i_data_byte;
                    o_state.pending_channel = CHAN_SYSTEM;
                    if (w_need == NEED_ZERO) begin
                        o_emit                = 1'b1;
                        o_state.pending_type  = ST_NONE;
                        o_state.bytes_awaited = 2'd0;
                        o_state.held_data     = 7'd0;
                        o_result = f_finish(i_data_byte, CHAN_SYSTEM, 7'd0, 7'd0,
                                            i_time_stamp);
                    end else begin
                        o_state.bytes_awaited = w_need;
                    end
                end
            end
        end else if (i_state.running_status != ST_NONE) begin
            o_state.pending_type    = w_run_type;
            o_state.pending_channel = {1'b0, i_state.running_status[3:0]};
            if (f_data_needed(w_run_type) == NEED_ONE) begin
                o_emit                = 1'b1;
                o_state.pending_type  = ST_NONE;
                o_state.bytes_awaited = 2'd0;
                o_state.held_data     = 7'd0;
                o_result = f_finish(w_run_type, {1'b0, i_state.running_status[3:0]},
                                    i_data_byte[6:0], 7'd0, i_time_stamp);
            end else begin
                o_state.held_data     = i_data_byte[6:0];
                o_state.bytes_awaited = NEED_ONE;
            end
        end
    end

endmodule

// ===== sv/mbsp_skid.sv =====
// Result register with a one-word skid stage for the MIDI parser.
// Depends on mbsp_pkg.
module mbsp_skid
    import mbsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_free;

    assign w_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_free) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_out       <= i_result;
                r_out_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (i_push) begin
            // Park the new word while the output is held.
            r_skid       <= i_result;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== sv/midi_byte_stream_parser_unit.sv =====
// Top level of the MIDI byte stream parser: parser state register, per-byte
// decode and result skid buffer. Depends on mbsp_pkg, mbsp_step, mbsp_skid.
//
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+---------------------------
//  input    | in        | i_in_valid / o_in_stall    | data byte + time stamp
//  output   | out       | o_out_valid / i_out_stall  | decoded event or SysEx byte
//
// One byte is accepted per cycle while the skid stage has room; its result
// word is decoded combinationally and registered in the output stage.
// Reset clears the running status, pending message and SysEx count at once.
// A stalled output holds its word; one more word parks in the skid stage, and
// the input stalls only while that stage is full.
module midi_byte_stream_parser_unit
    import mbsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [63:0] i_time_stamp,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_message_type,
    output logic [4:0]  o_channel,
    output logic [6:0]  o_first_data,
    output logic [6:0]  o_second_data,
    output logic [13:0] o_wide_value,
    output logic [15:0] o_sysex_length,
    output logic [63:0] o_event_time
);

    t_state  r_state;
    t_state  n_state;
    logic    w_emit;
    logic    w_accept;
    logic    w_full;
    t_result w_result;
    t_result w_out;

    // Accept whenever the skid stage has room.
    assign w_accept   = i_in_valid && !w_full;
    assign o_in_stall = w_full;

    mbsp_step u_step (
        .i_state      (r_state),
        .i_data_byte  (i_data_byte),
        .i_time_stamp (i_time_stamp),
        .o_state      (n_state),
        .o_emit       (w_emit),
        .o_result     (w_result)
    );

    // Advance the parser state only on an accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    mbsp_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_accept && w_emit),
        .i_result (w_result),
        .o_full   (w_full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (w_out)
    );

    assign o_result_kind  = w_out.result_kind;
    assign o_message_type = w_out.message_type;
    assign o_channel      = w_out.channel;
    assign o_first_data   = w_out.first_data;
    assign o_second_data  = w_out.second_data;
    assign o_wide_value   = w_out.wide_value;
    assign o_sysex_length = w_out.sysex_length;
    assign o_event_time   = w_out.event_time;

    // A parked word always sits behind a valid output word.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> o_out_valid)
        else $error("skid word present without output word");

    // A result produced while the output is held must land in the skid stage.
    a_park_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall && !w_full && w_accept && w_emit) |=> w_full)
        else $error("result lost while output stalled");

    // Inside SysEx the pending type stays the SysEx code.
    a_sysex_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.in_sysex |-> (r_state.pending_type == ST_SYSEX))
        else $error("SysEx active with wrong pending type");

    // Awaited data implies a defined pending message outside SysEx.
    a_await_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.bytes_awaited != 2'd0) |->
            (r_state.pending_type != ST_NONE && !r_state.in_sysex))
        else $error("data awaited without pending message");

endmodule

// ===== tb/tb_midi_byte_stream_parser_unit.sv =====
// Self-checking testbench for midi_byte_stream_parser_unit: random and directed
// MIDI byte streams, a byte-level predictor and an in-order scoreboard.
// Depends on mbsp_pkg and the parser RTL.
module tb_midi_byte_stream_parser_unit;
    import mbsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Status bytes that the parser must drop. The package only names the
    // defined ones.
    localparam logic [7:0] SC_UNDEF_1 = 8'hF1;
    localparam logic [7:0] SC_UNDEF_4 = 8'hF4;
    localparam logic [7:0] SC_UNDEF_5 = 8'hF5;
    localparam logic [7:0] RT_UNDEF_9 = 8'hF9;
    localparam logic [7:0] RT_UNDEF_D = 8'hFD;

    localparam int RANDOM_BYTES    = 370;
    localparam int BURST_PAYLOAD   = 40;     // SysEx payload during the receiver hold-off
    localparam int RX_HOLD_CYCLES  = 100;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int MAX_REPORTS     = 40;

    typedef struct packed {
        logic [7:0]  data;
        logic [63:0] stamp;
        logic        drain;    // hold this word back until no result is owed
    } t_timed_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic [63:0] i_time_stamp = 64'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_result_kind;
    logic [7:0]  o_message_type;
    logic [4:0]  o_channel;
    logic [6:0]  o_first_data;
    logic [6:0]  o_second_data;
    logic [13:0] o_wide_value;
    logic [15:0] o_sysex_length;
    logic [63:0] o_event_time;

    midi_byte_stream_parser_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_time_stamp   (i_time_stamp),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_kind  (o_result_kind),
        .o_message_type (o_message_type),
        .o_channel      (o_channel),
        .o_first_data   (o_first_data),
        .o_second_data  (o_second_data),
        .o_wide_value   (o_wide_value),
        .o_sysex_length (o_sysex_length),
        .o_event_time   (o_event_time)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser predictor. Mirrors the running-status parser one byte at a
    // time; its state only moves when a word is accepted at the input.
    // ------------------------------------------------------------------
    logic [7:0]                  run_status  = ST_NONE;
    logic [7:0]                  msg_type    = ST_NONE;
    logic [4:0]                  msg_chan    = 5'd0;
    logic [1:0]                  data_left   = NEED_ZERO;
    logic [6:0]                  first_held  = 7'd0;
    logic                        sysex_open  = 1'b0;
    logic [SYSEX_COUNT_BITS-1:0] sysex_bytes = '0;

    t_result     pending_events [$];   // decoded words still owed by the parser
    t_timed_byte byte_queue [$];       // bytes not yet offered at the input

    // Data bytes a status (channel nibble cleared) pulls in after itself.
    function automatic logic [1:0] data_count(input logic [7:0] status);
        case (status)
            ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CONTROL,
            ST_PITCH_BEND, ST_SONG_POS:                return NEED_TWO;
            ST_PROGRAM, ST_CHAN_PRESS, ST_SONG_SEL:    return NEED_ONE;
            ST_TUNE_REQ, ST_CLOCK, ST_START, ST_CONTINUE,
            ST_STOP, ST_SENSE, ST_RESET:               return NEED_ZERO;
            default:                                   return NEED_UNKNOWN;
        endcase
    endfunction

    // Build the event for the message being collected and drop back to idle.
    function automatic logic close_message(input logic [6:0] a, input logic [6:0] b,
                                           input logic [63:0] ts, output t_result ev);
        logic [7:0]  mtype;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [13:0] wide;
        mtype = msg_type;
        d1    = 7'd0;
        d2    = 7'd0;
        wide  = 14'd0;
        case (mtype)
            ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CONTROL: begin
                d1 = a;
                d2 = b;
                // Note-on at zero velocity is a note-off, and note-offs
                // never carry a velocity.
                if (mtype == ST_NOTE_ON && b == 7'd0)
                    mtype = ST_NOTE_OFF;
                if (mtype == ST_NOTE_OFF)
                    d2 = 7'd0;
            end
            ST_PROGRAM, ST_CHAN_PRESS, ST_SONG_SEL: d1 = a;
            ST_PITCH_BEND, ST_SONG_POS:             wide = {b, a};
            default: ;
        endcase
        ev = '{KIND_EVENT, mtype, msg_chan, d1, d2, wide, 16'd0, ts};
        msg_type   = ST_NONE;
        data_left  = NEED_ZERO;
        first_held = 7'd0;
        return 1'b1;
    endfunction

    // Advance the predictor by one byte; return 1 when the byte yields a word.
    function automatic logic decode_midi_byte(input logic [7:0] b, input logic [63:0] ts,
                                              output t_result ev);
        logic [1:0]  need;
        logic [15:0] len;
        // Inside SysEx everything but the end marker is payload.
        if (sysex_open) begin
            if (b == ST_EOX) begin
                len = (sysex_bytes > 'hFFFF) ? 16'hFFFF : 16'(sysex_bytes);
                sysex_open  = 1'b0;
                sysex_bytes = '0;
                msg_type    = ST_NONE;
                ev = '{KIND_EVENT, ST_SYSEX, CHAN_SYSTEM, 7'd0, 7'd0, 14'd0, len, ts};
                return 1'b1;
            end
            if (sysex_bytes != '1)
                sysex_bytes = sysex_bytes + 1'b1;
            ev = '{KIND_SYSEX, ST_SYSEX, CHAN_SYSTEM, b[6:0], 7'd0, 14'd0, 16'd0, ts};
            return 1'b1;
        end
        // While data is owed, any byte is data in its low seven bits.
        if (data_left != NEED_ZERO) begin
            if (data_left >= NEED_TWO) begin
                first_held = b[6:0];
                data_left  = NEED_ONE;
                return 1'b0;
            end
            if (data_count(msg_type) == NEED_TWO)
                return close_message(first_held, b[6:0], ts, ev);
            return close_message(b[6:0], 7'd0, ts, ev);
        end
        if (b[7]) begin
            if (b < ST_SYSEX) begin
                run_status = b;
                msg_type   = b & TYPE_MASK;
                msg_chan   = {1'b0, b[3:0]};
                data_left  = data_count(msg_type);
                return 1'b0;
            end
            // System common clears running status; real-time leaves it.
            if (b < ST_CLOCK)
                run_status = ST_NONE;
            if (b == ST_SYSEX) begin
                sysex_open  = 1'b1;
                sysex_bytes = '0;
                msg_type    = ST_SYSEX;
                msg_chan    = CHAN_SYSTEM;
                return 1'b0;
            end
            need = data_count(b);
            if (need == NEED_UNKNOWN)
                return 1'b0;
            msg_type = b;
            msg_chan = CHAN_SYSTEM;
            if (need == NEED_ZERO)
                return close_message(7'd0, 7'd0, ts, ev);
            data_left = need;
            return 1'b0;
        end
        // Bare data byte: only meaningful under running status.
        if (run_status == ST_NONE)
            return 1'b0;
        msg_type = run_status & TYPE_MASK;
        msg_chan = {1'b0, run_status[3:0]};
        if (data_count(msg_type) == NEED_ONE)
            return close_message(b[6:0], 7'd0, ts, ev);
        first_held = b[6:0];
        data_left  = NEED_ONE;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Bookkeeping shared by driver, receiver and monitor.
    // ------------------------------------------------------------------
    int   items_total     = 0;
    int   items_accepted  = 0;
    int   hold_at         = 0;   // index of the first byte of the hold-off burst
    int   mismatches      = 0;
    int   events_checked  = 0;
    int   sysex_checked   = 0;
    int   longest_sysex   = 0;
    int   input_stalls    = 0;
    int   idle_cycles     = 0;
    bit   timed_out       = 1'b0;
    bit   byte_taken      = 1'b0;
    bit   hold_done       = 1'b0;
    int   hold_left       = 0;
    int   tx_gap          = 0;
    int   rx_gap          = 0;

    // Idle length for either side. Some stretches run flat out: the burst
    // under the receiver hold-off and a slice of every 160 words.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((items_accepted >= hold_at && items_accepted <= hold_at + BURST_PAYLOAD + 1)
            || (items_accepted % 160) < 30)
            return 0;
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [6:0] data7();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 7'd0;
        if (r == 1)
            return 7'h7F;
        return 7'($urandom_range(0, 127));
    endfunction

    // Mostly a clean data byte; now and then a stray status byte that the
    // parser swallows as data wherever data is owed.
    function automatic logic [7:0] payload_byte();
        if ($urandom_range(0, 99) < 8)
            return 8'($urandom_range(8'h80, 8'hFF));
        return {1'b0, data7()};
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input bit drain);
        t_timed_byte w;
        int r;
        r = $urandom_range(0, 19);
        w.data  = b;
        w.drain = drain;
        if (r == 0)
            w.stamp = 64'd0;
        else if (r == 1)
            w.stamp = '1;
        else
            w.stamp = {$urandom, $urandom};
        byte_queue.push_back(w);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next byte at the falling edge once the previous
    // word has been taken; hold the payload steady while stalled.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        t_timed_byte w;
        if (i_rst_n && (!i_in_valid || byte_taken)) begin
            byte_taken = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (byte_queue.size() != 0
                         && !(byte_queue[0].drain && pending_events.size() != 0)) begin
                w = byte_queue.pop_front();
                i_data_byte  <= w.data;
                i_time_stamp <= w.stamp;
                i_in_valid   <= 1'b1;
                tx_gap = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off right after the
    // burst opener so the skid stage fills and the input backs up.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && items_accepted > hold_at) begin
            hold_done = 1'b1;
            hold_left = RX_HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_out_stall <= 1'b1;
        end else begin
            rx_gap = pick_gap();
            i_out_stall <= (rx_gap > 0);
            if (rx_gap > 0)
                rx_gap--;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. Check the output
    // word first, then feed an accepted input byte to the predictor.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result want;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            moved = 1'b1;
            if (pending_events.size() == 0) begin
                report_mismatch("word with nothing owed, message_type",
                                64'(o_message_type), 64'd0);
            end else begin
                want = pending_events.pop_front();
                if (o_result_kind !== want.result_kind)
                    report_mismatch("result_kind", 64'(o_result_kind),
                                    64'(want.result_kind));
                if (o_message_type !== want.message_type)
                    report_mismatch("message_type", 64'(o_message_type),
                                    64'(want.message_type));
                if (o_channel !== want.channel)
                    report_mismatch("channel", 64'(o_channel), 64'(want.channel));
                if (o_first_data !== want.first_data)
                    report_mismatch("first_data", 64'(o_first_data),
                                    64'(want.first_data));
                if (o_second_data !== want.second_data)
                    report_mismatch("second_data", 64'(o_second_data),
                                    64'(want.second_data));
                if (o_wide_value !== want.wide_value)
                    report_mismatch("wide_value", 64'(o_wide_value),
                                    64'(want.wide_value));
                if (o_sysex_length !== want.sysex_length)
                    report_mismatch("sysex_length", 64'(o_sysex_length),
                                    64'(want.sysex_length));
                if (o_event_time !== want.event_time)
                    report_mismatch("event_time", o_event_time, want.event_time);
                if (want.result_kind == KIND_SYSEX) begin
                    sysex_checked++;
                end else begin
                    events_checked++;
                    if (want.message_type == ST_SYSEX
                        && int'(want.sysex_length) > longest_sysex)
                        longest_sysex = int'(want.sysex_length);
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_stall)
            input_stalls++;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            moved = 1'b1;
            byte_taken = 1'b1;
            items_accepted++;
            if (decode_midi_byte(i_data_byte, i_time_stamp, want))
                pending_events.push_back(want);
        end
        // Watchdog: count cycles in which no word moves on either side.
        if (moved)
            idle_cycles = 0;
        else if (i_rst_n)
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES)
            timed_out = 1'b1;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] opening [$];
        logic [7:0] st;
        logic [7:0] b;
        int         r;
        int         reps;
        int         n;

        // Directed opener: most message families, running status, note-on at
        // zero velocity, forced note-off velocity, status bytes taken as data,
        // a bare data byte with no running status, dropped status bytes, and
        // SysEx with status and real-time bytes in its payload plus an empty one.
        opening = '{
            ST_NOTE_ON | 8'd0, 8'h00, 8'h7F,
            8'h7F, 8'h00,
            ST_NOTE_OFF | 8'd15, 8'h40, 8'h55,
            ST_CONTROL | 8'd14, ST_NOTE_ON, ST_CLOCK,
            ST_PROGRAM | 8'd5, 8'h7F,
            8'h12,
            ST_PITCH_BEND | 8'd3, 8'h7F, 8'h7F,
            ST_SONG_POS, 8'h00, 8'h00,
            8'h45,
            ST_SONG_SEL, 8'h05,
            ST_TUNE_REQ, ST_RESET, RT_UNDEF_9, SC_UNDEF_4, ST_EOX,
            ST_SYSEX, 8'h01, ST_CLOCK, ST_PITCH_BEND | 8'd10, ST_EOX,
            ST_SYSEX, ST_EOX
        };
        foreach (opening[i])
            queue_byte(opening[i], 1'b0);

        // Burst under the receiver hold-off. Its opener also waits until
        // every owed word has drained.
        hold_at = byte_queue.size();
        queue_byte(ST_SYSEX, 1'b1);
        repeat (BURST_PAYLOAD)
            queue_byte({1'b0, data7()}, 1'b0);
        queue_byte(ST_EOX, 1'b0);

        // Random part: mostly well-formed messages with random content.
        n = byte_queue.size();
        while (byte_queue.size() < n + RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                st = 8'($urandom_range(ST_NOTE_OFF, 8'hEF));
                queue_byte(st, $urandom_range(0, 99) < 3);
                reps = $urandom_range(1, 3);
                repeat (reps) begin
                    queue_byte(payload_byte(), 1'b0);
                    if ((st & TYPE_MASK) != ST_PROGRAM && (st & TYPE_MASK) != ST_CHAN_PRESS)
                        queue_byte(payload_byte(), 1'b0);
                end
            end else if (r < 62) begin
                case ($urandom_range(0, 2))
                    0: begin
                        queue_byte(ST_SONG_POS, 1'b0);
                        queue_byte(payload_byte(), 1'b0);
                        queue_byte(payload_byte(), 1'b0);
                    end
                    1: begin
                        queue_byte(ST_SONG_SEL, 1'b0);
                        queue_byte(payload_byte(), 1'b0);
                    end
                    default: queue_byte(ST_TUNE_REQ, 1'b0);
                endcase
            end else if (r < 72) begin
                queue_byte(8'($urandom_range(ST_CLOCK, ST_RESET)), 1'b0);
            end else if (r < 77) begin
                case ($urandom_range(0, 4))
                    0:       queue_byte(SC_UNDEF_1, 1'b0);
                    1:       queue_byte(SC_UNDEF_4, 1'b0);
                    2:       queue_byte(SC_UNDEF_5, 1'b0);
                    3:       queue_byte(RT_UNDEF_D, 1'b0);
                    default: queue_byte(ST_EOX, 1'b0);
                endcase
            end else if (r < 90) begin
                queue_byte(ST_SYSEX, $urandom_range(0, 99) < 5);
                reps = $urandom_range(0, 12);
                repeat (reps) begin
                    b = payload_byte();
                    if (b == ST_EOX)
                        b = ST_CLOCK;
                    queue_byte(b, 1'b0);
                end
                queue_byte(ST_EOX, 1'b0);
            end else begin
                // Noise: raw bytes of any value, bare data and broken messages.
                reps = $urandom_range(1, 3);
                repeat (reps)
                    queue_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end

        // Close any SysEx left open by the noise.
        queue_byte(ST_EOX, 1'b0);
        items_total = byte_queue.size();

        // Hold reset, then let the driver go.
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!timed_out && (items_accepted < items_total || pending_events.size() != 0))
            @(posedge i_clk);

        if (timed_out)
            $display("Watchdog expired: %0d of %0d bytes taken, %0d words still owed",
                     items_accepted, items_total, pending_events.size());
        else
            repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d bytes: %0d decoded events and %0d SysEx payload words, %0s",
                 items_accepted, events_checked, sysex_checked,
                 "with running status, dropped status bytes and bytes taken as data.");
        $display("Longest SysEx length %0d; input held off %0d cycles; %0d mismatches.",
                 longest_sysex, input_stalls, mismatches);
        if (!timed_out && mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
